### rtl/impulse_response_convolver_assert.svh
// assertion macros used by the convolver controller
`ifndef IMPULSE_RESPONSE_CONVOLVER_ASSERT_SVH
`define IMPULSE_RESPONSE_CONVOLVER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define IRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("irc assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define IRC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("irc assertion failed");

`endif

### rtl/irc_pkg.sv
// shared types and constants of the impulse response convolver
package irc_pkg;

    localparam int NUM_SETS  = 3;
    localparam int MIN_TAPS  = 3;
    localparam int SMP_W     = 16;
    localparam int TAPC_W    = 10;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 10;
    localparam int SHIFT_CAB = 17;
    localparam int SHIFT_DRY = 15;

    localparam logic [CFG_AW-1:0] CFG_CAB_MIC   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SHAPED    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TAP_COUNT = 2'd2;

    localparam logic       FUNC_SAMPLE = 1'b0;
    localparam logic       FUNC_LOAD   = 1'b1;

    localparam logic [1:0] SET_HEAD = 2'd0;
    localparam logic [1:0] SET_BOTH = 2'd1;
    localparam logic [1:0] SET_CAB  = 2'd2;

    localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic load;
        logic bypass;
        logic start;
        logic issue;
        logic finish;
        logic out_load;
    } t_irc_cmd;

    typedef struct packed {
        logic bypass;
        logic last;
        logic pipe_busy;
    } t_irc_stat;

endpackage

### rtl/irc_datapath.sv
// convolver datapath: config registers, history and coefficient memories, mac pipeline
module irc_datapath
    import irc_pkg::*;
#(
    parameter int MAX_TAPS = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic signed [SMP_W-1:0] i_sample_in,
    input  logic [1:0]              i_coef_set,
    input  logic [8:0]              i_coef_index,
    input  logic signed [SMP_W-1:0] i_coef_value,
    input  t_irc_cmd                i_cmd,
    output t_irc_stat               o_stat,
    output logic signed [SMP_W-1:0] o_sample_out
);

    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int CMP_W      = (CNT_W > TAPC_W) ? CNT_W : TAPC_W;
    localparam int COEF_DEPTH = NUM_SETS * MAX_TAPS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int PROD_W     = 2 * SMP_W;
    localparam int ACC_W      = PROD_W + CNT_W;
    localparam int HALF_CAB   = 1 << (SHIFT_CAB - 1);
    localparam int HALF_DRY   = 1 << (SHIFT_DRY - 1);

    logic                     r_cab_mic;
    logic                     r_shaped;
    logic [TAPC_W-1:0]        r_tap_count;

    logic [SMP_W-1:0]         r_hist_mem [MAX_TAPS];
    logic [SMP_W-1:0]         r_coef_mem [COEF_DEPTH];

    logic [TAP_W-1:0]         r_wp;
    logic [CNT_W-1:0]         r_fill;
    logic [TAP_W-1:0]         r_k;
    logic [TAP_W-1:0]         r_y;
    logic [TAP_W-1:0]         r_n_m1;
    logic [CA_W-1:0]          r_base;
    logic                     r_cab;

    logic signed [SMP_W-1:0]  r_c;
    logic signed [SMP_W-1:0]  r_h;
    logic                     r_hv;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SMP_W-1:0]  r_res;
    logic signed [SMP_W-1:0]  r_out;

    logic [CMP_W-1:0]         w_tc;
    logic [CNT_W-1:0]         w_n;
    logic [TAP_W-1:0]         w_wp0;
    logic [CNT_W-1:0]         w_wp_inc;
    logic [TAP_W-1:0]         w_wp_next;
    logic [1:0]               w_run_set;
    logic                     w_load_ok;
    logic [CA_W-1:0]          w_load_addr;
    logic [CA_W-1:0]          w_rd_addr;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W:0]    w_sh;
    logic signed [SMP_W-1:0]  w_sat;

    function automatic logic [CA_W-1:0] f_base(input logic [1:0] s);
        logic [CA_W-1:0] b;
        unique case (s)
            SET_BOTH: b = CA_W'(MAX_TAPS);
            SET_CAB:  b = CA_W'(2 * MAX_TAPS);
            default:  b = '0;
        endcase
        return b;
    endfunction

    // effective tap count and bypass decision
    assign w_tc = CMP_W'(r_tap_count);
    assign w_n  = (w_tc > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(w_tc);

    assign o_stat.bypass    = (w_n < CNT_W'(MIN_TAPS)) || (!r_cab_mic && !r_shaped);
    assign o_stat.last      = (r_k == r_n_m1);
    assign o_stat.pipe_busy = r_v1 || r_v2;

    // write position with stale wrap
    assign w_wp0     = (CNT_W'(r_wp) >= w_n) ? '0 : r_wp;
    assign w_wp_inc  = CNT_W'(w_wp0) + CNT_W'(1);
    assign w_wp_next = (w_wp_inc == w_n) ? '0 : TAP_W'(w_wp_inc);

    always_comb begin
        if (r_cab_mic && r_shaped) begin
            w_run_set = SET_BOTH;
        end else if (r_cab_mic) begin
            w_run_set = SET_CAB;
        end else begin
            w_run_set = SET_HEAD;
        end
    end

    assign w_load_ok   = (32'(i_coef_set) < NUM_SETS)
                         && (CMP_W'(i_coef_index) < CMP_W'(MAX_TAPS));
    assign w_load_addr = f_base(i_coef_set) + CA_W'(TAP_W'(CMP_W'(i_coef_index)));
    assign w_rd_addr   = r_base + CA_W'(r_k);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cab_mic   <= 1'b0;
            r_shaped    <= 1'b1;
            r_tap_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CAB_MIC:   r_cab_mic   <= i_cfg_wdata[0];
                CFG_SHAPED:    r_shaped    <= i_cfg_wdata[0];
                CFG_TAP_COUNT: r_tap_count <= i_cfg_wdata[TAPC_W-1:0];
                default:       ;
            endcase
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hist_mem[w_wp0] <= i_sample_in;
        end
        r_h <= r_hist_mem[r_y];
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_coef_mem[w_load_addr] <= i_coef_value;
        end
        r_c <= r_coef_mem[w_rd_addr];
    end

    // control registers of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_wp <= w_wp_next;
                if (w_wp_inc > r_fill) begin
                    r_fill <= w_wp_inc;
                end
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // run setup, address walk and mac
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_k    <= '0;
            r_y    <= w_wp0;
            r_n_m1 <= TAP_W'(w_n - CNT_W'(1));
            r_base <= f_base(w_run_set);
            r_cab  <= r_cab_mic;
        end else if (i_cmd.issue) begin
            r_k <= r_k + TAP_W'(1);
            r_y <= (r_y == '0) ? r_n_m1 : r_y - TAP_W'(1);
        end
        // never-written history reads as zero
        r_hv   <= (CNT_W'(r_y) < r_fill);
        r_prod <= r_c * (r_hv ? r_h : SMP_W'(0));
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up and saturate
    assign w_sum = (ACC_W + 1)'(r_acc)
                   + (r_cab ? (ACC_W + 1)'(HALF_CAB) : (ACC_W + 1)'(HALF_DRY));
    assign w_sh  = r_cab ? (w_sum >>> SHIFT_CAB) : (w_sum >>> SHIFT_DRY);

    always_comb begin
        if (w_sh > (ACC_W + 1)'(SAT_MAX)) begin
            w_sat = SAT_MAX;
        end else if (w_sh < (ACC_W + 1)'(SAT_MIN)) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_sh[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bypass) begin
            r_res <= i_sample_in;
        end else if (i_cmd.finish) begin
            r_res <= w_sat;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sample_out = r_out;

endmodule

### rtl/irc_controller.sv
// convolver controller: request handshake, tap sequencing and output register control
`include "impulse_response_convolver_assert.svh"

module irc_controller
    import irc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    input  logic      i_func,
    input  logic      i_m_tready,
    input  t_irc_stat i_stat,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    output t_irc_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_acc;
    logic   w_slot_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_stat.bypass) begin
                        o_cmd.bypass = 1'b1;
                        n_state      = S_PUT;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.finish = 1'b1;
                n_state      = S_PUT;
            end
            S_PUT: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `IRC_ASSERT_NXT(a_start_runs,
        r_state == S_IDLE && w_acc && i_func == FUNC_SAMPLE && !i_stat.bypass,
        r_state == S_RUN)
    `IRC_ASSERT_NXT(a_put_delivers, r_state == S_PUT && w_slot_free,
        r_out_valid && r_state == S_IDLE)
    `IRC_ASSERT_IMP(a_round_after_drain, r_state == S_ROUND, !i_stat.pipe_busy)

endmodule

### rtl/impulse_response_convolver.sv
// impulse response convolver top level: ports, field unpacking, controller and datapath
//
// input stream s_axis: tuser 0 takes one audio sample, tuser 1 loads one coefficient
// into impulse set 0 (head), 1 (head plus cabinet) or 2 (cabinet only).
// a load gives no output; a sample gives exactly one output on m_axis.
// config port: write enable, register index (0 cab_mic, 1 shaped, 2 tap_count), data;
// write only while the block is idle.
// bypassed sample (tap_count below 3, or neither cab_mic nor shaped): the sample
// goes to the result register, then the output register; the next request follows.
// convolved sample: n taps run through one shared multiply-accumulate, one tap per
// cycle from the coefficient and history memories; the memory read, product and
// accumulator registers drain, the sum is rounded into the result register and then
// loaded into the output register; the next request is taken after that.
// a load writes its coefficient as it is accepted, and the block stays idle.
// reset: cab_mic 0, shaped 1, tap_count 0, history reads as zero until written
// (tracked by a fill count, no clearing pass); coefficients hold nothing valid.
// a stalled receiver holds the output register; one more finished result waits
// inside and the input stalls until the register frees up.
module impulse_response_convolver
    import irc_pkg::*;
#(
    parameter int MAX_TAPS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // sample_in [15:0], coef_set [17:16], coef_index [26:18], coef_value [42:27]
    input  logic [47:0]       i_s_axis_tdata,
    // func [0]
    input  logic              i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // sample_out [15:0]
    output logic [15:0]       o_m_axis_tdata
);

    t_irc_cmd                w_cmd;
    t_irc_stat               w_stat;
    logic signed [SMP_W-1:0] w_sample_out;

    irc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_func     (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    irc_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_s_axis_tdata[15:0]),
        .i_coef_set   (i_s_axis_tdata[17:16]),
        .i_coef_index (i_s_axis_tdata[26:18]),
        .i_coef_value (i_s_axis_tdata[42:27]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_sample_out (w_sample_out)
    );

    assign o_m_axis_tdata = w_sample_out;

endmodule
